/* rtl/blr_pkg.sv */
`timescale 1ns / 1ps

package blr_pkg;

   // Grid size of the tile and width of the error term.
   localparam int COORD_BITS = 6;
   localparam int FIELD_BITS = 6;
   localparam int COLOR_BITS = 24;
   localparam int ERR_BITS   = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [FIELD_BITS-1:0]      field_type;
   typedef logic [COLOR_BITS-1:0]      color_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   // One segment request.
   typedef struct packed {
      field_type start_x;
      field_type start_y;
      field_type end_x;
      field_type end_y;
      color_type line_color;
   } req_data_type;

   // One emitted pixel.
   typedef struct packed {
      field_type pixel_x;
      field_type pixel_y;
      color_type pixel_color;
      logic      last_pixel;
   } rsp_data_type;

   // Control of the shared error-term unit.
   typedef struct packed {
      logic load;
      logic advance;
      logic rising;
   } err_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK
   } state_type;

endpackage

/* rtl/blr_err_unit.sv */
`timescale 1ns / 1ps

module blr_err_unit (
   input  logic                 clock,
   input  blr_pkg::err_ctrl_type ctrl,
   input  blr_pkg::coord_type   major_len,
   input  blr_pkg::coord_type   minor_len,
   output logic                 step
);
   import blr_pkg::*;

   err_type err_ff, err_in;
   err_type inc_step_ff, inc_step_in;
   err_type inc_flat_ff, inc_flat_in;
   err_type two_minor;
   err_type two_major;
   err_type add_a;
   err_type add_b;
   err_type sum;

   // Doubled lengths, zero-extended into the error width.
   assign two_minor = err_type'({minor_len, 1'b0});
   assign two_major = err_type'({major_len, 1'b0});

   // The minor axis moves on a tie only when it rises.
   always_comb begin
      if (ctrl.rising) begin
         step = ~err_ff[ERR_BITS-1];
      end else begin
         step = ~err_ff[ERR_BITS-1] && (err_ff != '0);
      end
   end

   // One shared adder: initial term at load, running update while walking.
   always_comb begin
      if (ctrl.load) begin
         add_a = two_minor;
         add_b = -err_type'(major_len);
      end else begin
         add_a = err_ff;
         add_b = step ? inc_step_ff : inc_flat_ff;
      end
      sum = add_a + add_b;
   end

   always_comb begin
      err_in      = err_ff;
      inc_step_in = inc_step_ff;
      inc_flat_in = inc_flat_ff;
      if (ctrl.load) begin
         err_in      = sum;
         inc_step_in = two_minor - two_major;
         inc_flat_in = two_minor;
      end else if (ctrl.advance) begin
         err_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      inc_step_ff <= inc_step_in;
      inc_flat_ff <= inc_flat_in;
   end

endmodule

/* rtl/blr_seq.sv */
`timescale 1ns / 1ps

module blr_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  blr_pkg::req_data_type req_data,
   input  logic                  out_free,
   output logic                  emit,
   output blr_pkg::rsp_data_type pixel,
   output blr_pkg::err_ctrl_type err_ctrl,
   output blr_pkg::coord_type    major_len,
   output blr_pkg::coord_type    minor_len,
   input  logic                  step
);
   import blr_pkg::*;

   state_type state_ff, state_in;

   coord_type ax_ff, ay_ff, bx_ff, by_ff;
   color_type color_ff;
   coord_type m_ff, m_in;
   coord_type n_ff, n_in;
   coord_type m_end_ff, m_end_in;
   logic      xmaj_ff, xmaj_in;
   logic      rising_ff, rising_in;

   logic signed [COORD_BITS:0] dx_s;
   logic signed [COORD_BITS:0] dy_s;
   logic signed [COORD_BITS:0] dx_abs;
   logic signed [COORD_BITS:0] dy_abs;
   coord_type adx, ady;
   logic      xmaj, swap;
   coord_type m0, n0, m1, n1;
   logic      accept;
   logic      last;
   coord_type px, py;

   assign accept = req_valid && !req_stall;

   // Setup geometry from the captured endpoints.
   always_comb begin
      dx_s   = $signed({1'b0, bx_ff}) - $signed({1'b0, ax_ff});
      dy_s   = $signed({1'b0, by_ff}) - $signed({1'b0, ay_ff});
      dx_abs = dx_s[COORD_BITS] ? -dx_s : dx_s;
      dy_abs = dy_s[COORD_BITS] ? -dy_s : dy_s;
      adx    = dx_abs[COORD_BITS-1:0];
      ady    = dy_abs[COORD_BITS-1:0];
      xmaj   = (ady <= adx);
      swap   = xmaj ? (ax_ff > bx_ff) : (ay_ff > by_ff);
      if (xmaj) begin
         m0 = swap ? bx_ff : ax_ff;
         n0 = swap ? by_ff : ay_ff;
         m1 = swap ? ax_ff : bx_ff;
         n1 = swap ? ay_ff : by_ff;
      end else begin
         m0 = swap ? by_ff : ay_ff;
         n0 = swap ? bx_ff : ax_ff;
         m1 = swap ? ay_ff : by_ff;
         n1 = swap ? ax_ff : bx_ff;
      end
      major_len = xmaj ? adx : ady;
      minor_len = xmaj ? ady : adx;
   end

   // Current pixel in screen axes.
   assign last = (m_ff == m_end_ff);
   assign px   = xmaj_ff ? m_ff : n_ff;
   assign py   = xmaj_ff ? n_ff : m_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // A zero-length segment has no pixels.
            if (major_len == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (out_free && last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and walk datapath.
   always_comb begin
      req_stall        = 1'b1;
      emit             = 1'b0;
      err_ctrl.load    = 1'b0;
      err_ctrl.advance = 1'b0;
      err_ctrl.rising  = rising_ff;
      m_in             = m_ff;
      n_in             = n_ff;
      m_end_in         = m_end_ff;
      xmaj_in          = xmaj_ff;
      rising_in        = rising_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SETUP: begin
            err_ctrl.load = 1'b1;
            m_in          = m0;
            n_in          = n0;
            m_end_in      = m1;
            xmaj_in       = xmaj;
            rising_in     = (n1 >= n0);
         end
         ST_WALK: begin
            if (out_free) begin
               emit             = 1'b1;
               err_ctrl.advance = 1'b1;
               m_in             = m_ff + coord_type'(1);
               if (step) begin
                  n_in = rising_ff ? n_ff + coord_type'(1) : n_ff - coord_type'(1);
               end
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      pixel.pixel_x     = field_type'(px);
      pixel.pixel_y     = field_type'(py);
      pixel.pixel_color = color_ff;
      pixel.last_pixel  = last;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Segment payload and walk registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff    <= coord_type'(req_data.start_x);
         ay_ff    <= coord_type'(req_data.start_y);
         bx_ff    <= coord_type'(req_data.end_x);
         by_ff    <= coord_type'(req_data.end_y);
         color_ff <= req_data.line_color;
      end
      m_ff      <= m_in;
      n_ff      <= n_in;
      m_end_ff  <= m_end_in;
      xmaj_ff   <= xmaj_in;
      rising_ff <= rising_in;
   end

endmodule

/* rtl/bresenham_line_raster_top.sv */
`timescale 1ns / 1ps

// Bresenham line rasterizer. Each request transaction carries one segment; the
// block answers with one response transaction per pixel, both endpoints
// included, walked along the major axis from its smaller end, with last_pixel
// set on the final one. A segment whose endpoints coincide gives no pixels. A
// segment is captured, then set up, then walked at one pixel per cycle while
// the output register can take it, N = max(|dx|, |dy|) + 1 pixels in all. The
// rate is set by the single error-term adder, which is updated once per pixel.
// Requests are held off until the last pixel of the current segment has
// entered the output register; response stall only pauses the walk.
module bresenham_line_raster_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  blr_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output blr_pkg::rsp_data_type rsp_data
);
   import blr_pkg::*;

   logic         out_free;
   logic         emit;
   rsp_data_type pixel;
   err_ctrl_type err_ctrl;
   coord_type    major_len;
   coord_type    minor_len;
   logic         step;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff;

   blr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .emit      (emit),
      .pixel     (pixel),
      .err_ctrl  (err_ctrl),
      .major_len (major_len),
      .minor_len (minor_len),
      .step      (step)
   );

   blr_err_unit u_err (
      .clock     (clock),
      .ctrl      (err_ctrl),
      .major_len (major_len),
      .minor_len (minor_len),
      .step      (step)
   );

   // Output register takes a new pixel when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= pixel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* dv/blr_checker.sv */
`timescale 1ns / 1ps

// Scoreboard for the line rasterizer. It watches both channels, traces every
// accepted segment into the pixels it must produce, and compares each pixel
// that leaves the block with the oldest one still waiting.
module blr_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  blr_pkg::req_data_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  blr_pkg::rsp_data_type rsp_data,
   output int                    error_count,
   output int                    pixels_pending,
   output int                    segments_taken,
   output int                    empty_segments,
   output int                    pixels_checked
);
   import blr_pkg::*;

   // Only the first mismatches are printed; the rest are just counted.
   localparam int REPORT_LIMIT = 40;

   rsp_data_type expected_pixels[$];
   rsp_data_type want;
   int           errors;
   int           segments;
   int           empties;
   int           checked;

   // Trace one segment with the integer error term and queue its pixels.
   function automatic void trace_segment(input req_data_type seg);
      int           ax, ay, bx, by, tmp;
      int           span, lean, err, major_pos, minor_pos, minor_step, k;
      bit           x_major, ties_step;
      rsp_data_type pix;
      ax = int'(seg.start_x);
      ay = int'(seg.start_y);
      bx = int'(seg.end_x);
      by = int'(seg.end_y);
      x_major = ((by > ay) ? by - ay : ay - by) <= ((bx > ax) ? bx - ax : ax - bx);
      // The walk always climbs the major axis, so start from its lower end.
      if (x_major ? (ax > bx) : (ay > by)) begin
         tmp = ax; ax = bx; bx = tmp;
         tmp = ay; ay = by; by = tmp;
      end
      span      = x_major ? bx - ax : by - ay;
      lean      = x_major ? by - ay : bx - ax;
      major_pos = x_major ? ax : ay;
      minor_pos = x_major ? ay : ax;
      segments++;
      if (span == 0) begin
         empties++;
         return;
      end
      // Mirror a falling minor axis onto a rising one. The only difference
      // left is that an exact tie steps the minor axis only when it rises.
      ties_step  = (lean >= 0);
      minor_step = ties_step ? 1 : -1;
      if (!ties_step)
         lean = -lean;
      err = 2 * lean - span;
      for (k = 0; k <= span; k++) begin
         pix.pixel_x     = field_type'(x_major ? major_pos + k : minor_pos);
         pix.pixel_y     = field_type'(x_major ? minor_pos : major_pos + k);
         pix.pixel_color = seg.line_color;
         pix.last_pixel  = (k == span);
         expected_pixels.push_back(pix);
         if (err > 0 || (ties_step && err == 0)) begin
            minor_pos += minor_step;
            err       += 2 * (lean - span);
         end else begin
            err += 2 * lean;
         end
      end
   endfunction

   // Compare one field of a pixel and report it when it differs.
   task automatic compare_field(input string name, input logic [31:0] expected_val,
                                input logic [31:0] actual_val);
      if (expected_val !== actual_val) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, expected_val, actual_val);
      end
   endtask

   // Check outgoing pixels first, then trace any newly accepted segment.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected pixel, expected none, actual 0x%0h",
                           $time, rsp_data);
            end else begin
               want = expected_pixels.pop_front();
               checked++;
               compare_field("pixel_x", 32'(want.pixel_x), 32'(rsp_data.pixel_x));
               compare_field("pixel_y", 32'(want.pixel_y), 32'(rsp_data.pixel_y));
               compare_field("pixel_color", 32'(want.pixel_color),
                             32'(rsp_data.pixel_color));
               compare_field("last_pixel", 32'(want.last_pixel),
                             32'(rsp_data.last_pixel));
            end
         end
         if (req_valid && !req_stall)
            trace_segment(req_data);
      end
      error_count    <= errors;
      pixels_pending <= expected_pixels.size();
      segments_taken <= segments;
      empty_segments <= empties;
      pixels_checked <= checked;
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

// Top of the line rasterizer bench: drives segments with random gaps and
// random output stalls, and gives the verdict from the checker's counts.
module tb;
   import blr_pkg::*;

   // Cycles without any accepted transaction before the run is declared hung.
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_SEGMENTS = 95;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;

   bit           sender_idles = 1'b1;
   bit           receiver_stalls = 1'b1;
   int           quiet_cycles = 0;

   int           error_count;
   int           pixels_pending;
   int           segments_taken;
   int           empty_segments;
   int           pixels_checked;

   bresenham_line_raster_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   blr_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .pixels_pending (pixels_pending),
      .segments_taken (segments_taken),
      .empty_segments (empty_segments),
      .pixels_checked (pixels_checked)
   );

   always #5 clock = ~clock;

   // The receiver stalls now and then, unless told to stay ready.
   always @(posedge clock) begin
      rsp_stall <= receiver_stalls && ($urandom_range(99) < 8);
   end

   // Watchdog: give up when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired at %0t after %0d quiet cycles.", $time, quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_data_type line_seg(input int sx, input int sy, input int ex,
                                             input int ey, input color_type color);
      req_data_type seg;
      seg.start_x    = field_type'(sx);
      seg.start_y    = field_type'(sy);
      seg.end_x      = field_type'(ex);
      seg.end_y      = field_type'(ey);
      seg.line_color = color;
      return seg;
   endfunction

   // A coordinate within a few pixels of c, kept inside the tile.
   function automatic int nearby(input int c);
      int v;
      v = c + $urandom_range(8) - 4;
      return (v < 0) ? 0 : (v > 63) ? 63 : v;
   endfunction

   // Offer one segment and hold it until the block takes it.
   task automatic send_segment(input req_data_type seg);
      if (sender_idles && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(70, 1)) @(posedge clock);
      end
      req_data  <= seg;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering segments until every predicted pixel has come out.
   task automatic drain_pixels();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pixels_pending == 0);
      @(posedge clock);
   endtask

   initial begin
      int        i, kind, sx, sy;
      color_type color;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed segments: empty ones, full-tile spans, diagonals, ties in
      // each direction, all eight octants and the shortest real segments.
      send_segment(line_seg(0, 0, 0, 0, 24'h000000));
      send_segment(line_seg(63, 63, 63, 63, 24'hFFFFFF));
      send_segment(line_seg(0, 0, 63, 0, 24'hFFFFFF));
      send_segment(line_seg(63, 63, 0, 63, 24'h000000));
      send_segment(line_seg(0, 0, 0, 63, 24'hAAAAAA));
      send_segment(line_seg(63, 63, 63, 0, 24'h555555));
      send_segment(line_seg(0, 0, 63, 63, 24'h123456));
      send_segment(line_seg(63, 0, 0, 63, 24'hFEDCBA));
      send_segment(line_seg(0, 63, 63, 0, 24'h800001));
      send_segment(line_seg(63, 63, 0, 0, 24'h7FFFFE));
      send_segment(line_seg(0, 0, 2, 1, 24'h0F0F0F));
      send_segment(line_seg(0, 1, 2, 0, 24'hF0F0F0));
      send_segment(line_seg(0, 0, 1, 2, 24'h00FF00));
      send_segment(line_seg(1, 0, 0, 2, 24'hFF00FF));
      send_segment(line_seg(10, 10, 30, 17, 24'h111111));
      send_segment(line_seg(30, 17, 10, 10, 24'h222222));
      send_segment(line_seg(10, 17, 30, 10, 24'h333333));
      send_segment(line_seg(30, 10, 10, 17, 24'h444444));
      send_segment(line_seg(10, 10, 17, 30, 24'h666666));
      send_segment(line_seg(17, 30, 10, 10, 24'h777777));
      send_segment(line_seg(17, 10, 10, 30, 24'h888888));
      send_segment(line_seg(10, 30, 17, 10, 24'h999999));
      send_segment(line_seg(5, 5, 6, 5, 24'hC3C3C3));
      send_segment(line_seg(40, 20, 40, 21, 24'h3C3C3C));
      send_segment(line_seg(0, 1, 63, 0, 24'hA5A5A5));
      drain_pixels();

      // Random segments: mostly with endpoints anywhere in the tile, some short,
      // a few empty. A quiet stretch in the middle runs with no gaps and no stalls.
      for (i = 0; i < RANDOM_SEGMENTS; i++) begin
         if (i == 40) begin
            sender_idles    = 1'b0;
            receiver_stalls <= 1'b0;
         end else if (i == 80) begin
            sender_idles    = 1'b1;
            receiver_stalls <= 1'b1;
            drain_pixels();
         end
         kind  = $urandom_range(99);
         color = color_type'($urandom());
         sx    = $urandom_range(63);
         sy    = $urandom_range(63);
         if (kind < 8)
            send_segment(line_seg(sx, sy, sx, sy, color));
         else if (kind < 35)
            send_segment(line_seg(sx, sy, nearby(sx), nearby(sy), color));
         else
            send_segment(line_seg(sx, sy, $urandom_range(63), $urandom_range(63), color));
      end

      // Let the last segment finish and give stray pixels time to show up.
      drain_pixels();
      repeat (100) @(posedge clock);

      $display("Ran %0d segments (%0d empty), %0d pixels checked, %0d errors.",
               segments_taken, empty_segments, pixels_checked, error_count);
      $display("Covered all octants, tie steps both ways, full-tile spans and stalls.");
      if (error_count == 0 && pixels_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
